// ===== rtl/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants of the magnetometer bus sequencer.
// ----------------------------------------------------------------------------
package mbs_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Z    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_MAP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_NEGATE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIELD_FLOOR = 3'd6;

   localparam logic [5:0]  AXIS_MAP_RESET    = 6'd36;
   localparam logic [14:0] FIELD_LIMIT_RESET = 15'd1000;
   localparam logic [14:0] FIELD_FLOOR_RESET = 15'd400;
   localparam logic [15:0] UNIT_GAIN         = 16'd16384;
   localparam logic [23:0] CAL_NUMER         = 24'd11468800;

   localparam logic [7:0] SENSOR_WR_ADDR = 8'h3C;
   localparam logic [7:0] SENSOR_RD_ADDR = 8'h3D;
   localparam logic [7:0] REG_A_NORMAL   = 8'h10;
   localparam logic [7:0] REG_A_BIAS     = 8'h11;
   localparam logic [7:0] REG_B_GAIN     = 8'h20;
   localparam logic [7:0] MODE_RUN       = 8'h00;
   localparam logic [7:0] MODE_SINGLE    = 8'h01;
   localparam logic [7:0] MODE_IDLE      = 8'h02;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_STOP    = 3'd2,
      CMD_SEND    = 3'd3,
      CMD_RECEN   = 3'd4,
      CMD_ACK     = 3'd5,
      CMD_RESTART = 3'd6,
      CMD_SHUT    = 3'd7
   } bus_cmd_type;

   typedef enum logic [3:0] {
      XF_IDLE     = 4'd0,
      XF_WR_START = 4'd1,
      XF_WR_DATA  = 4'd2,
      XF_WR_STOP  = 4'd3,
      XF_RD_START = 4'd4,
      XF_RD_ADDR  = 4'd5,
      XF_RD_CHECK = 4'd6,
      XF_RD_STORE = 4'd7,
      XF_RD_AGAIN = 4'd8,
      XF_RD_STOP  = 4'd9,
      XF_RD_DONE  = 4'd10
   } xfer_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_CAL,
      CTL_MEAS,
      CTL_RESP
   } ctl_state_type;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_CAL_CHECK,
      DP_CAL_DIV,
      DP_MUL,
      DP_ACC,
      DP_DONE
   } dp_state_type;

   typedef struct packed {
      logic       cal_start;
      logic       meas_start;
      logic       store_en;
      logic [2:0] store_idx;
      logic [7:0] store_byte;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic cal_fail;
      logic meas_ok;
   } dp_status_type;

endpackage

// ===== rtl/mbs_dpath.sv =====
// ----------------------------------------------------------------------------
// mbs_dpath
// Receive buffer, gains, field values, serial divider and scaling multiplier.
// ----------------------------------------------------------------------------
module mbs_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mbs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  mbs_pkg::dp_cmd_type                 cmd,
   output mbs_pkg::dp_status_type              status,
   output logic signed [15:0]                  field_x,
   output logic signed [15:0]                  field_y,
   output logic signed [15:0]                  field_z
);

   logic signed [15:0] offset_ff [3];
   logic [5:0]         axis_map_ff;
   logic [2:0]         negate_ff;
   logic [14:0]        limit_ff;
   logic [14:0]        floor_ff;

   logic [7:0]         buf_ff [6];
   logic [15:0]        gain_ff [3];
   logic [15:0]        hold_ff [3];

   mbs_pkg::dp_state_type state_ff, state_in;
   logic [1:0]         axis_ff;
   logic               fail_ff;
   logic               ok_ff;
   logic [4:0]         cnt_ff;
   logic [23:0]        num_ff;
   logic [14:0]        rem_ff;
   logic [23:0]        quo_ff;
   logic [14:0]        divisor_ff;
   logic signed [32:0] prod_ff;

   // raw axis selection
   logic [1:0]         sel_axis;
   logic [1:0]         map_bits;
   logic signed [15:0] raw;
   logic               in_range;

   // divider step
   logic [15:0]        trial;
   logic               take;
   logic [14:0]        rem_next;
   logic [23:0]        quo_next;

   // scaling
   logic signed [18:0] scaled;
   logic signed [18:0] signed_val;
   logic signed [19:0] diff;
   logic signed [15:0] vout;
   logic [16:0]        mag;
   logic               last_axis;

   always_comb begin
      map_bits = axis_map_ff[{axis_ff, 1'b0} +: 2];
      if (state_ff == mbs_pkg::DP_MUL) begin
         sel_axis = (map_bits == 2'd3) ? 2'd2 : map_bits;
      end else begin
         sel_axis = axis_ff;
      end
      raw = $signed({buf_ff[{sel_axis, 1'b0}], buf_ff[{sel_axis, 1'b1}]});
      in_range = (raw > $signed({1'b0, floor_ff})) && (raw < $signed({1'b0, limit_ff}));
      last_axis = (axis_ff == 2'd2);
   end

   always_comb begin
      trial    = {rem_ff, num_ff[23]};
      take     = (trial >= {1'b0, divisor_ff});
      rem_next = take ? 15'(trial - {1'b0, divisor_ff}) : trial[14:0];
      quo_next = {quo_ff[22:0], take};
   end

   always_comb begin
      scaled     = 19'(prod_ff >>> 14);
      signed_val = negate_ff[axis_ff] ? -scaled : scaled;
      diff       = 20'(signed_val) - 20'(offset_ff[axis_ff] >>> 1);
      vout       = diff[15:0];
      mag        = vout[15] ? 17'(-$signed({vout[15], vout})) : {1'b0, vout};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbs_pkg::DP_IDLE: begin
            if (cmd.cal_start) begin
               state_in = mbs_pkg::DP_CAL_CHECK;
            end else if (cmd.meas_start) begin
               state_in = mbs_pkg::DP_MUL;
            end
         end
         mbs_pkg::DP_CAL_CHECK: begin
            if (in_range) begin
               state_in = mbs_pkg::DP_CAL_DIV;
            end else if (last_axis) begin
               state_in = mbs_pkg::DP_DONE;
            end
         end
         mbs_pkg::DP_CAL_DIV: begin
            if (cnt_ff == 5'd23) begin
               state_in = last_axis ? mbs_pkg::DP_DONE : mbs_pkg::DP_CAL_CHECK;
            end
         end
         mbs_pkg::DP_MUL: state_in = mbs_pkg::DP_ACC;
         mbs_pkg::DP_ACC: state_in = last_axis ? mbs_pkg::DP_DONE : mbs_pkg::DP_MUL;
         mbs_pkg::DP_DONE: state_in = mbs_pkg::DP_IDLE;
         default: state_in = mbs_pkg::DP_IDLE;
      endcase
   end

   always_comb begin
      status.done     = (state_ff == mbs_pkg::DP_DONE);
      status.cal_fail = fail_ff;
      status.meas_ok  = ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mbs_pkg::DP_IDLE;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
         axis_map_ff <= mbs_pkg::AXIS_MAP_RESET;
         negate_ff   <= '0;
         limit_ff    <= mbs_pkg::FIELD_LIMIT_RESET;
         floor_ff    <= mbs_pkg::FIELD_FLOOR_RESET;
         gain_ff[0]  <= mbs_pkg::UNIT_GAIN;
         gain_ff[1]  <= mbs_pkg::UNIT_GAIN;
         gain_ff[2]  <= mbs_pkg::UNIT_GAIN;
         hold_ff[0]  <= '0;
         hold_ff[1]  <= '0;
         hold_ff[2]  <= '0;
         axis_ff     <= '0;
         fail_ff     <= 1'b0;
         ok_ff       <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               mbs_pkg::CSR_OFFSET_X:    offset_ff[0] <= csr_wdata;
               mbs_pkg::CSR_OFFSET_Y:    offset_ff[1] <= csr_wdata;
               mbs_pkg::CSR_OFFSET_Z:    offset_ff[2] <= csr_wdata;
               mbs_pkg::CSR_AXIS_MAP:    axis_map_ff  <= csr_wdata[5:0];
               mbs_pkg::CSR_AXIS_NEGATE: negate_ff    <= csr_wdata[2:0];
               mbs_pkg::CSR_FIELD_LIMIT: limit_ff     <= csr_wdata[14:0];
               mbs_pkg::CSR_FIELD_FLOOR: floor_ff     <= csr_wdata[14:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            mbs_pkg::DP_IDLE: begin
               axis_ff <= '0;
               if (cmd.cal_start) fail_ff <= 1'b0;
               if (cmd.meas_start) ok_ff <= 1'b1;
            end
            mbs_pkg::DP_CAL_CHECK: begin
               cnt_ff <= '0;
               if (!in_range) begin
                  gain_ff[axis_ff] <= mbs_pkg::UNIT_GAIN;
                  fail_ff <= 1'b1;
                  axis_ff <= axis_ff + 2'd1;
               end
            end
            mbs_pkg::DP_CAL_DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd23) begin
                  gain_ff[axis_ff] <= (quo_next[23:16] != 8'd0) ? 16'hFFFF : quo_next[15:0];
                  axis_ff <= axis_ff + 2'd1;
               end
            end
            mbs_pkg::DP_ACC: begin
               hold_ff[axis_ff] <= vout;
               if (mag >= {2'b00, limit_ff}) ok_ff <= 1'b0;
               axis_ff <= axis_ff + 2'd1;
            end
            default: ;
         endcase
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (cmd.store_en && cmd.store_idx < 3'd6) begin
         buf_ff[cmd.store_idx] <= cmd.store_byte;
      end
      if (state_ff == mbs_pkg::DP_CAL_CHECK) begin
         num_ff     <= mbs_pkg::CAL_NUMER;
         rem_ff     <= '0;
         quo_ff     <= '0;
         divisor_ff <= raw[14:0];
      end else if (state_ff == mbs_pkg::DP_CAL_DIV) begin
         num_ff <= {num_ff[22:0], 1'b0};
         rem_ff <= rem_next;
         quo_ff <= quo_next;
      end
      if (state_ff == mbs_pkg::DP_MUL) begin
         prod_ff <= raw * $signed({1'b0, gain_ff[sel_axis]});
      end
   end

   assign field_x = hold_ff[0];
   assign field_y = hold_ff[1];
   assign field_z = hold_ff[2];

endmodule

// ===== rtl/mbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbs_ctrl
// Phase and transfer sequencer; holds the bus side of the response.
// ----------------------------------------------------------------------------
module mbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic                    req_bus_enabled,
   input  logic                    req_bus_normal,
   input  logic                    req_receive_active,
   input  logic                    req_nack_received,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_bus_command,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_ack_level,
   output logic                    rsp_field_ready,
   output logic                    rsp_drift_request,
   output logic [2:0]              rsp_phase,
   output mbs_pkg::dp_cmd_type     dp_cmd,
   input  mbs_pkg::dp_status_type  dp_status
);

   mbs_pkg::ctl_state_type state_ff, state_in;
   mbs_pkg::xfer_type      xfer_ff, xfer_in;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [1:0]  sel_ff, sel_in;
   mbs_pkg::bus_cmd_type   cmd_ff, cmd_in;
   logic [7:0]  tx_ff, tx_in;
   logic        ack_ff, ack_in;
   logic        ready_ff, ready_in;
   logic        drift_ff, drift_in;

   logic        accept;
   logic        go_cal, go_meas;
   logic [2:0]  idx_inc;
   logic [7:0]  cmd_byte;

   assign accept  = req_valid && (state_ff == mbs_pkg::CTL_IDLE);
   assign idx_inc = (idx_ff < 3'd7) ? idx_ff + 3'd1 : idx_ff;

   always_comb begin
      unique case (idx_ff)
         3'd0: cmd_byte = mbs_pkg::SENSOR_WR_ADDR;
         3'd1: cmd_byte = 8'h00;
         3'd2: cmd_byte = (sel_ff == 2'd1) ? mbs_pkg::REG_A_BIAS : mbs_pkg::REG_A_NORMAL;
         3'd3: cmd_byte = mbs_pkg::REG_B_GAIN;
         default: cmd_byte = (sel_ff == 2'd1) ? mbs_pkg::MODE_SINGLE :
                             (sel_ff == 2'd2) ? mbs_pkg::MODE_IDLE : mbs_pkg::MODE_RUN;
      endcase
   end

   assign go_cal  = accept && req_action && xfer_ff == mbs_pkg::XF_RD_DONE && phase_ff == 3'd5;
   assign go_meas = accept && req_action && xfer_ff == mbs_pkg::XF_RD_DONE && phase_ff == 3'd7;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbs_pkg::CTL_IDLE: begin
            if (go_cal) state_in = mbs_pkg::CTL_CAL;
            else if (go_meas) state_in = mbs_pkg::CTL_MEAS;
            else if (accept) state_in = mbs_pkg::CTL_RESP;
         end
         mbs_pkg::CTL_CAL, mbs_pkg::CTL_MEAS: begin
            if (dp_status.done) state_in = mbs_pkg::CTL_RESP;
         end
         mbs_pkg::CTL_RESP: begin
            if (!rsp_stall) state_in = mbs_pkg::CTL_IDLE;
         end
         default: state_in = mbs_pkg::CTL_IDLE;
      endcase
   end

   // sequencing registers and response fields
   always_comb begin
      xfer_in  = xfer_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      sel_in   = sel_ff;
      cmd_in   = cmd_ff;
      tx_in    = tx_ff;
      ack_in   = ack_ff;
      ready_in = ready_ff;
      drift_in = drift_ff;
      dp_cmd.cal_start  = go_cal;
      dp_cmd.meas_start = go_meas;
      dp_cmd.store_en   = 1'b0;
      dp_cmd.store_idx  = idx_ff;
      dp_cmd.store_byte = req_rx_byte;
      if (accept) begin
         cmd_in   = mbs_pkg::CMD_NONE;
         tx_in    = 8'h00;
         ack_in   = 1'b0;
         ready_in = 1'b0;
         drift_in = 1'b0;
         if (!req_action) begin
            if (!req_bus_enabled) begin
               xfer_in = mbs_pkg::XF_IDLE; phase_in = 3'd0; cmd_in = mbs_pkg::CMD_RESTART;
            end else if (!req_bus_normal) begin
               xfer_in = mbs_pkg::XF_IDLE; phase_in = 3'd0; cmd_in = mbs_pkg::CMD_SHUT;
            end else begin
               idx_in = 3'd0;
               phase_in = (phase_ff < 3'd7) ? phase_ff + 3'd1 : phase_ff;
               if (phase_in[0]) begin
                  xfer_in = mbs_pkg::XF_RD_START;
               end else begin
                  sel_in = (phase_in == 3'd2) ? 2'd2 : (phase_in == 3'd4) ? 2'd1 : 2'd0;
                  xfer_in = mbs_pkg::XF_WR_START;
               end
            end
         end else begin
            unique case (xfer_ff)
               mbs_pkg::XF_WR_START: begin
                  xfer_in = mbs_pkg::XF_WR_DATA; cmd_in = mbs_pkg::CMD_START;
               end
               mbs_pkg::XF_WR_DATA: begin
                  tx_in = cmd_byte; cmd_in = mbs_pkg::CMD_SEND; idx_in = idx_inc;
                  if (idx_inc > 3'd4) xfer_in = mbs_pkg::XF_WR_STOP;
               end
               mbs_pkg::XF_WR_STOP: begin
                  xfer_in = mbs_pkg::XF_IDLE; cmd_in = mbs_pkg::CMD_STOP;
               end
               mbs_pkg::XF_RD_START: begin
                  if (!req_receive_active) begin
                     xfer_in = mbs_pkg::XF_RD_ADDR; cmd_in = mbs_pkg::CMD_START;
                  end
               end
               mbs_pkg::XF_RD_ADDR: begin
                  xfer_in = mbs_pkg::XF_RD_CHECK; cmd_in = mbs_pkg::CMD_SEND;
                  tx_in = mbs_pkg::SENSOR_RD_ADDR;
               end
               mbs_pkg::XF_RD_CHECK: begin
                  if (req_nack_received) begin
                     phase_in = 3'd0; cmd_in = mbs_pkg::CMD_STOP; xfer_in = mbs_pkg::XF_IDLE;
                  end else begin
                     cmd_in = mbs_pkg::CMD_RECEN; xfer_in = mbs_pkg::XF_RD_STORE;
                  end
               end
               mbs_pkg::XF_RD_STORE: begin
                  dp_cmd.store_en = 1'b1;
                  idx_in = idx_inc;
                  cmd_in = mbs_pkg::CMD_ACK;
                  if (idx_inc > 3'd6) begin
                     ack_in = 1'b1; xfer_in = mbs_pkg::XF_RD_STOP;
                  end else begin
                     xfer_in = mbs_pkg::XF_RD_AGAIN;
                  end
               end
               mbs_pkg::XF_RD_AGAIN: begin
                  cmd_in = mbs_pkg::CMD_RECEN; xfer_in = mbs_pkg::XF_RD_STORE;
               end
               mbs_pkg::XF_RD_STOP: begin
                  cmd_in = mbs_pkg::CMD_STOP; xfer_in = mbs_pkg::XF_RD_DONE;
               end
               mbs_pkg::XF_RD_DONE: begin
                  xfer_in = mbs_pkg::XF_IDLE;
                  ready_in = go_meas;
               end
               default: ;
            endcase
         end
      end else if (dp_status.done) begin
         if (state_ff == mbs_pkg::CTL_CAL) begin
            if (dp_status.cal_fail) phase_in = 3'd0;
         end else if (state_ff == mbs_pkg::CTL_MEAS) begin
            if (dp_status.meas_ok) drift_in = 1'b1;
            else phase_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbs_pkg::CTL_IDLE;
         xfer_ff  <= mbs_pkg::XF_IDLE;
         phase_ff <= '0;
         idx_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         xfer_ff  <= xfer_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      tx_ff    <= tx_in;
      ack_ff   <= ack_in;
      ready_ff <= ready_in;
      drift_ff <= drift_in;
   end

   assign req_stall         = (state_ff != mbs_pkg::CTL_IDLE);
   assign rsp_valid         = (state_ff == mbs_pkg::CTL_RESP);
   assign rsp_bus_command   = cmd_ff;
   assign rsp_tx_byte       = tx_ff;
   assign rsp_ack_level     = ack_ff;
   assign rsp_field_ready   = ready_ff;
   assign rsp_drift_request = drift_ff;
   assign rsp_phase         = phase_ff;

endmodule

// ===== rtl/magnetometer_bus_sequencer.sv =====
// ----------------------------------------------------------------------------
// magnetometer_bus_sequencer
// Steps a magnetometer through reset, calibration and data reads over a
// byte-level two-wire bus controller, one request per bus event or tick.
// ----------------------------------------------------------------------------
// Ticks and plain bus events: accepted in CTL_IDLE, answered from CTL_RESP.
// Calibration evaluation runs, for each in-range axis, the 24-step serial
//   divider that forms its gain. Data evaluation passes each axis through the
//   shared multiplier (DP_MUL, then DP_ACC) before the hand-off.
// Throughput: one request at a time; the next is taken once the response left.
// Reset: synchronous; phase 0, transfer idle, gains 16384, field values 0.

module magnetometer_bus_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic                                req_bus_enabled,
   input  logic                                req_bus_normal,
   input  logic                                req_receive_active,
   input  logic                                req_nack_received,
   input  logic [7:0]                          req_rx_byte,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_bus_command,
   output logic [7:0]                          rsp_tx_byte,
   output logic                                rsp_ack_level,
   output logic signed [15:0]                  rsp_field_x,
   output logic signed [15:0]                  rsp_field_y,
   output logic signed [15:0]                  rsp_field_z,
   output logic                                rsp_field_ready,
   output logic                                rsp_drift_request,
   output logic [2:0]                          rsp_phase,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mbs_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   mbs_pkg::dp_cmd_type    dp_cmd;
   mbs_pkg::dp_status_type dp_status;

   // registers are always writable; software must write them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // sequencer: phases, transfer steps, bus command of each response
   mbs_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_bus_enabled    (req_bus_enabled),
      .req_bus_normal     (req_bus_normal),
      .req_receive_active (req_receive_active),
      .req_nack_received  (req_nack_received),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_bus_command    (rsp_bus_command),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_ack_level      (rsp_ack_level),
      .rsp_field_ready    (rsp_field_ready),
      .rsp_drift_request  (rsp_drift_request),
      .rsp_phase          (rsp_phase),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status)
   );

   // datapath: sample buffer, gain divider, field scaling
   mbs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .field_x   (rsp_field_x),
      .field_y   (rsp_field_y),
      .field_z   (rsp_field_z)
   );

   // one request in flight: a pending response blocks new requests
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("request accepted while response pending");

   // drift request only comes from a successful data read in the last phase
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drift_request) |-> (rsp_field_ready && rsp_phase == 3'd7))
      else $error("drift request outside data phase");

   // an evaluation step never issues a bus command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_field_ready) |-> (rsp_bus_command == mbs_pkg::CMD_NONE))
      else $error("bus command on evaluation step");

   // a datapath job starts only while the sequencer is taking a request
   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.cal_start || dp_cmd.meas_start) |=> req_stall)
      else $error("datapath started without a request");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the magnetometer bus sequencer. A queue of bus
// events and service ticks feeds a driver; a monitor compares each response
// with the result of a predictor that mirrors the sequencer's phase and
// transfer state, gains and calibrated field values.
// ----------------------------------------------------------------------------
module testbench;

   // request as the predictor and driver see it
   typedef struct packed {
      logic       action;
      logic       bus_enabled;
      logic       bus_normal;
      logic       receive_active;
      logic       nack_received;
      logic [7:0] rx_byte;
   } bus_event_type;

   typedef struct packed {
      logic [2:0]         bus_command;
      logic [7:0]         tx_byte;
      logic               ack_level;
      logic signed [15:0] field_x;
      logic signed [15:0] field_y;
      logic signed [15:0] field_z;
      logic               field_ready;
      logic               drift_request;
      logic [2:0]         phase;
   } seq_result_type;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 120;   // covers the calibration divider

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0, req_bus_enabled = 1'b0, req_bus_normal = 1'b0;
   logic req_receive_active = 1'b0, req_nack_received = 1'b0;
   logic [7:0] req_rx_byte = 8'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_bus_command;
   logic [7:0] rsp_tx_byte;
   logic rsp_ack_level;
   logic signed [15:0] rsp_field_x, rsp_field_y, rsp_field_z;
   logic rsp_field_ready, rsp_drift_request;
   logic [2:0] rsp_phase;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mbs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mbs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   magnetometer_bus_sequencer uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of registers and state
   logic [15:0] pr_offset [3];
   logic [5:0]  pr_axis_map;
   logic [2:0]  pr_axis_negate;
   logic [14:0] pr_limit, pr_floor;
   logic [2:0]  pr_phase;
   mbs_pkg::xfer_type pr_xfer;
   logic [2:0]  pr_byte_index;
   logic [1:0]  pr_cmd_sel;
   logic [7:0]  pr_rx_buf [6];
   logic [15:0] pr_gain [3];
   logic [15:0] pr_field [3];

   bus_event_type  pending_events[$];
   seq_result_type expected_results[$];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  sender_idle_pct = 11, receiver_idle_pct = 45;
   int  hold_cycles = 0;          // long receiver hold-off when nonzero
   bit  sender_paused = 1'b0;

   function automatic longint raw_value(int i);
      return longint'($signed({pr_rx_buf[2*i], pr_rx_buf[2*i+1]}));
   endfunction

   function automatic logic [7:0] write_byte(int idx);
      case (idx)
         0: return mbs_pkg::SENSOR_WR_ADDR;
         1: return 8'h00;
         2: return (pr_cmd_sel == 2'd1) ? mbs_pkg::REG_A_BIAS : mbs_pkg::REG_A_NORMAL;
         3: return mbs_pkg::REG_B_GAIN;
         default: return (pr_cmd_sel == 2'd1) ? mbs_pkg::MODE_SINGLE :
                         (pr_cmd_sel == 2'd2) ? mbs_pkg::MODE_IDLE : mbs_pkg::MODE_RUN;
      endcase
   endfunction

   task automatic predict_register(logic [mbs_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] data);
      case (idx)
         mbs_pkg::CSR_OFFSET_X:    pr_offset[0] = data;
         mbs_pkg::CSR_OFFSET_Y:    pr_offset[1] = data;
         mbs_pkg::CSR_OFFSET_Z:    pr_offset[2] = data;
         mbs_pkg::CSR_AXIS_MAP:    pr_axis_map = data[5:0];
         mbs_pkg::CSR_AXIS_NEGATE: pr_axis_negate = data[2:0];
         mbs_pkg::CSR_FIELD_LIMIT: pr_limit = data[14:0];
         mbs_pkg::CSR_FIELD_FLOOR: pr_floor = data[14:0];
         default: ;
      endcase
   endtask

   // gains from a finished calibration read
   function automatic void derive_gains();
      longint r;
      longint unsigned q;
      for (int i = 0; i < 3; i++) begin
         r = raw_value(i);
         if (r > longint'(pr_floor) && r < longint'(pr_limit)) begin
            q = 64'd11468800 / r;
            pr_gain[i] = (q > 65535) ? 16'hFFFF : q[15:0];
         end else begin
            pr_gain[i] = mbs_pkg::UNIT_GAIN;
            pr_phase = 3'd0;
         end
      end
   endfunction

   // calibrated field values; returns 1 when all lie within the limit
   function automatic bit derive_fields();
      bit ok = 1'b1;
      int a;
      longint prod, scaled, off, v, mag;
      for (int k = 0; k < 3; k++) begin
         a = pr_axis_map[2*k +: 2];
         if (a > 2) a = 2;
         prod = raw_value(a) * longint'(pr_gain[a]);
         scaled = prod >>> 14;
         if (pr_axis_negate[k]) scaled = -scaled;
         off = longint'($signed(pr_offset[k])) >>> 1;
         v = longint'($signed(16'(scaled - off)));
         pr_field[k] = v[15:0];
         mag = (v < 0) ? -v : v;
         if (!(mag < longint'(pr_limit))) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic seq_result_type predict_sequencer(bus_event_type ev);
      seq_result_type r;
      r = '0;
      r.bus_command = mbs_pkg::CMD_NONE;
      if (!ev.action) begin
         if (!ev.bus_enabled) begin
            pr_xfer = mbs_pkg::XF_IDLE; pr_phase = 3'd0; r.bus_command = mbs_pkg::CMD_RESTART;
         end else if (!ev.bus_normal) begin
            pr_xfer = mbs_pkg::XF_IDLE; pr_phase = 3'd0; r.bus_command = mbs_pkg::CMD_SHUT;
         end else begin
            pr_byte_index = 3'd0;
            if (pr_phase < 7) pr_phase++;
            if (pr_phase[0]) begin
               pr_xfer = mbs_pkg::XF_RD_START;
            end else begin
               pr_cmd_sel = (pr_phase == 2) ? 2'd2 : (pr_phase == 4) ? 2'd1 : 2'd0;
               pr_xfer = mbs_pkg::XF_WR_START;
            end
         end
      end else begin
         case (pr_xfer)
            mbs_pkg::XF_WR_START: begin
               pr_xfer = mbs_pkg::XF_WR_DATA; r.bus_command = mbs_pkg::CMD_START;
            end
            mbs_pkg::XF_WR_DATA: begin
               r.tx_byte = write_byte(pr_byte_index); r.bus_command = mbs_pkg::CMD_SEND;
               if (pr_byte_index < 7) pr_byte_index++;
               if (pr_byte_index > 4) pr_xfer = mbs_pkg::XF_WR_STOP;
            end
            mbs_pkg::XF_WR_STOP: begin
               pr_xfer = mbs_pkg::XF_IDLE; r.bus_command = mbs_pkg::CMD_STOP;
            end
            mbs_pkg::XF_RD_START: begin
               if (!ev.receive_active) begin
                  pr_xfer = mbs_pkg::XF_RD_ADDR; r.bus_command = mbs_pkg::CMD_START;
               end
            end
            mbs_pkg::XF_RD_ADDR: begin
               pr_xfer = mbs_pkg::XF_RD_CHECK; r.bus_command = mbs_pkg::CMD_SEND;
               r.tx_byte = mbs_pkg::SENSOR_RD_ADDR;
            end
            mbs_pkg::XF_RD_CHECK: begin
               if (ev.nack_received) begin
                  pr_phase = 3'd0; r.bus_command = mbs_pkg::CMD_STOP;
                  pr_xfer = mbs_pkg::XF_IDLE;
               end else begin
                  r.bus_command = mbs_pkg::CMD_RECEN; pr_xfer = mbs_pkg::XF_RD_STORE;
               end
            end
            mbs_pkg::XF_RD_STORE: begin
               if (pr_byte_index < 6) pr_rx_buf[pr_byte_index] = ev.rx_byte;
               if (pr_byte_index < 7) pr_byte_index++;
               r.bus_command = mbs_pkg::CMD_ACK;
               if (pr_byte_index > 6) begin
                  r.ack_level = 1'b1; pr_xfer = mbs_pkg::XF_RD_STOP;
               end else begin
                  pr_xfer = mbs_pkg::XF_RD_AGAIN;
               end
            end
            mbs_pkg::XF_RD_AGAIN: begin
               r.bus_command = mbs_pkg::CMD_RECEN; pr_xfer = mbs_pkg::XF_RD_STORE;
            end
            mbs_pkg::XF_RD_STOP: begin
               r.bus_command = mbs_pkg::CMD_STOP; pr_xfer = mbs_pkg::XF_RD_DONE;
            end
            mbs_pkg::XF_RD_DONE: begin
               pr_xfer = mbs_pkg::XF_IDLE;
               if (pr_phase == 7) begin
                  r.field_ready = 1'b1;
                  if (derive_fields()) r.drift_request = 1'b1;
                  else pr_phase = 3'd0;
               end else if (pr_phase == 5) begin
                  derive_gains();
               end
            end
            default: ;
         endcase
      end
      r.field_x = pr_field[0];
      r.field_y = pr_field[1];
      r.field_z = pr_field[2];
      r.phase = pr_phase;
      return r;
   endfunction

   // driver: a request is presented at the falling edge and held until taken
   bus_event_type cur_event;

   bit offered = 1'b0;  // request on the port not yet accepted
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_results.push_back(predict_sequencer(cur_event));
         offered <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (!reset && !offered && !sender_paused) begin
         if (pending_events.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            cur_event = pending_events.pop_front();
            {req_action, req_bus_enabled, req_bus_normal, req_receive_active,
             req_nack_received, req_rx_byte} <= cur_event;
            req_valid <= 1'b1;
            offered <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!offered) begin
         req_valid <= 1'b0;
      end
   end

   // receiver stall, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      seq_result_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_bus_command, rsp_tx_byte, rsp_ack_level, rsp_field_x, rsp_field_y,
                rsp_field_z, rsp_field_ready, rsp_drift_request, rsp_phase};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %h", got);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch (exp/got): cmd %0d/%0d tx %h/%h ack %b/%b",
                            " fx %0d/%0d fy %0d/%0d fz %0d/%0d rdy %b/%b",
                            " drift %b/%b phase %0d/%0d"},
                     want.bus_command, got.bus_command, want.tx_byte, got.tx_byte,
                     want.ack_level, got.ack_level, want.field_x, got.field_x,
                     want.field_y, got.field_y, want.field_z, got.field_z,
                     want.field_ready, got.field_ready, want.drift_request,
                     got.drift_request, want.phase, got.phase);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic bus_event_type make_event(bit act, logic [7:0] rx);
      bus_event_type e;
      e.action = act; e.bus_enabled = 1'b1; e.bus_normal = 1'b1;
      e.receive_active = 1'b0; e.nack_received = 1'b0; e.rx_byte = rx;
      return e;
   endfunction

   // one service tick and the events of the transfer it arms
   task automatic queue_cycle(bit in_range, bit noisy);
      bus_event_type e;
      int lim = (pr_limit > pr_floor + 1) ? pr_limit : 1000;
      logic [15:0] raw;
      pending_events.push_back(make_event(1'b0, 8'd0));
      if (noisy && $urandom_range(3) == 0) begin
         e = make_event(1'b1, 8'($urandom));
         e.receive_active = 1'b1;
         pending_events.push_back(e);
      end
      for (int i = 0; i < 2; i++) pending_events.push_back(make_event(1'b1, 8'($urandom)));
      e = make_event(1'b1, 8'($urandom));
      e.nack_received = noisy && ($urandom_range(15) == 0);
      pending_events.push_back(e);
      for (int b = 0; b < 3; b++) begin
         raw = in_range ? 16'($urandom_range(lim - 1, pr_floor + 1)) : 16'($urandom);
         if (in_range && $urandom_range(1)) raw = -raw;
         pending_events.push_back(make_event(1'b1, raw[15:8]));
         pending_events.push_back(make_event(1'b1, 8'($urandom)));
         pending_events.push_back(make_event(1'b1, raw[7:0]));
         pending_events.push_back(make_event(1'b1, 8'($urandom)));
      end
      for (int i = 0; i < 3; i++) pending_events.push_back(make_event(1'b1, 8'($urandom)));
   endtask

   task automatic wait_drained();
      while (pending_events.size() > 0 || offered || expected_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [mbs_pkg::CSR_INDEX_W-1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_index <= idx; csr_wdata <= data; csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      predict_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_noise(int n);
      bus_event_type e;
      for (int i = 0; i < n; i++) begin
         e = bus_event_type'(13'($urandom));
         e.bus_enabled = ($urandom_range(15) != 0);
         e.bus_normal = ($urandom_range(15) != 0);
         pending_events.push_back(e);
      end
   endtask

   initial begin
      bus_event_type e;
      pr_offset = '{default: 16'd0};
      pr_axis_map = mbs_pkg::AXIS_MAP_RESET; pr_axis_negate = 3'd0;
      pr_limit = mbs_pkg::FIELD_LIMIT_RESET; pr_floor = mbs_pkg::FIELD_FLOOR_RESET;
      pr_phase = 3'd0; pr_xfer = mbs_pkg::XF_IDLE; pr_byte_index = 3'd0; pr_cmd_sel = 2'd0;
      pr_rx_buf = '{default: 8'd0};
      pr_gain = '{default: mbs_pkg::UNIT_GAIN};
      pr_field = '{default: 16'd0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: restart, shut, stray event while idle, then a clean run-up
      e = make_event(1'b0, 8'd0); e.bus_enabled = 1'b0; pending_events.push_back(e);
      e = make_event(1'b0, 8'd0); e.bus_normal = 1'b0; pending_events.push_back(e);
      pending_events.push_back(make_event(1'b1, 8'hFF));
      // directed sequence is long; it walks every phase including writes
      for (int c = 0; c < 9; c++) queue_cycle(1'b1, 1'b0);
      // address nack and held-off start
      pending_events.push_back(make_event(1'b0, 8'd0));
      e = make_event(1'b1, 8'd0); e.receive_active = 1'b1; pending_events.push_back(e);
      pending_events.push_back(make_event(1'b1, 8'd0));
      pending_events.push_back(make_event(1'b1, 8'd0));
      e = make_event(1'b1, 8'd0); e.nack_received = 1'b1; pending_events.push_back(e);
      wait_drained();

      // register settings, extremes included
      for (int phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: begin sender_idle_pct = 11; receiver_idle_pct = 45; end
            2: begin sender_idle_pct = 45; receiver_idle_pct = 11; end
            4: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
            default: ;
         endcase
         write_register(mbs_pkg::CSR_OFFSET_X, (phase_no == 1) ? 16'h8000 :
                                      (phase_no == 2) ? 16'h7FFF : 16'($urandom));
         write_register(mbs_pkg::CSR_OFFSET_Y,
                        (phase_no == 1) ? 16'h7FFF : 16'($urandom_range(63)));
         write_register(mbs_pkg::CSR_OFFSET_Z, (phase_no == 1) ? 16'hFFFF : 16'($urandom));
         write_register(mbs_pkg::CSR_AXIS_MAP,
                        (phase_no == 1) ? 16'd63 : 16'($urandom_range(63)));
         write_register(mbs_pkg::CSR_AXIS_NEGATE,
                        (phase_no == 2) ? 16'd7 : 16'($urandom_range(7)));
         write_register(mbs_pkg::CSR_FIELD_LIMIT, (phase_no == 3) ? 16'd32767 :
                                         (phase_no == 5) ? 16'd0 :
                                         16'($urandom_range(4000, 200)));
         write_register(mbs_pkg::CSR_FIELD_FLOOR, (phase_no == 3) ? 16'd0 :
                                         (phase_no == 5) ? 16'd32767 :
                                         16'($urandom_range(150)));
         for (int c = 0; c < 9; c++) begin
            if ($urandom_range(4) == 0) queue_noise($urandom_range(6, 1));
            queue_cycle($urandom_range(7) != 0, 1'b1);
            if (phase_no == 1 && c == 3) begin
               hold_cycles = 400;        // block fills and stalls its input
            end
            if (phase_no == 3 && c == 4) begin
               sender_paused = 1'b1;     // let everything drain first
               while (offered || expected_results.size() > 0) @(posedge clock);
               sender_paused = 1'b0;
            end
         end
         wait_drained();
      end

      wait_drained();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
